### rtl/lph_pkg.sv
// Shared types and constants for the linear probing hash table.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package lph_pkg;

  localparam int SLOTS     = 16;
  localparam int SLOT_BITS = $clog2(SLOTS);
  localparam int KEY_BITS  = 31;

  // Golden-ratio fraction 0.6180339887 in unsigned 0.32 fixed point
  localparam logic [31:0] HOME_MULT = 32'd2654435769;

  // Request operation codes
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_MISS = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  // Probe token handed from cell to cell
  typedef struct packed {
    logic                 active;
    logic [1:0]           mode;
    logic [KEY_BITS-1:0]  key;
    logic [SLOT_BITS-1:0] home;
    logic                 hit;
    logic [SLOT_BITS-1:0] slot;
  } tok_t;

endpackage

### rtl/lph_hash.sv
// Home slot stage: multiplicative hash of the request key into a probe token.
// Depends on lph_pkg.
module lph_hash (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic [1:0]                   mode,
  input  logic [lph_pkg::KEY_BITS-1:0] key,
  output lph_pkg::tok_t                tok
);

  logic [31:0] frac;

  // Keep the low 32 bits of key times the golden-ratio fraction
  assign frac = 32'(32'(key) * lph_pkg::HOME_MULT);

  // Launch a fresh token; the top bits of the fraction pick the home slot
  always_ff @(posedge clk) begin
    if (rst) begin
      tok.active <= 1'b0;
    end else begin
      tok.active <= load;
    end
    tok.mode <= mode;
    tok.key  <= key;
    tok.home <= frac[31 -: lph_pkg::SLOT_BITS];
    tok.hit  <= 1'b0;
    tok.slot <= '0;
  end

endmodule

### rtl/lph_cell.sv
// One table slot: stored key, valid bit and the probe step for that slot.
// Depends on lph_pkg.
module lph_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [lph_pkg::SLOT_BITS-1:0] idx,
  input  lph_pkg::tok_t                 tok_in,
  output lph_pkg::tok_t                 tok_out
);

  logic                         slot_valid;
  logic [lph_pkg::KEY_BITS-1:0] slot_key;
  logic                         eligible;
  logic                         match;
  logic                         ins_hit;
  logic                         find_hit;
  logic                         del_hit;

  // Act only on a live token that has not settled and has reached its home slot
  assign eligible = tok_in.active && !tok_in.hit && (idx >= tok_in.home);
  assign match    = slot_valid && (slot_key == tok_in.key);
  assign ins_hit  = eligible && (tok_in.mode == lph_pkg::MODE_INSERT) && !slot_valid;
  assign find_hit = eligible && match &&
                    ((tok_in.mode == lph_pkg::MODE_LOOKUP) ||
                     (tok_in.mode == lph_pkg::MODE_DELETE));
  assign del_hit  = find_hit && (tok_in.mode == lph_pkg::MODE_DELETE);

  // Update the slot on insert or delete
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (ins_hit) begin
      slot_valid <= 1'b1;
    end else if (del_hit) begin
      slot_valid <= 1'b0;
    end
    if (ins_hit) begin
      slot_key <= tok_in.key;
    end
  end

  // Hand the token to the next cell, marking it settled here on a hit
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else begin
      tok_out.active <= tok_in.active;
    end
    tok_out.mode <= tok_in.mode;
    tok_out.key  <= tok_in.key;
    tok_out.home <= tok_in.home;
    if (ins_hit || find_hit) begin
      tok_out.hit  <= 1'b1;
      tok_out.slot <= idx;
    end else begin
      tok_out.hit  <= tok_in.hit;
      tok_out.slot <= tok_in.slot;
    end
  end

  a_insert_sets_valid: assert property (@(posedge clk) disable iff (rst)
    ins_hit |=> slot_valid)
    else $error("insert did not mark slot valid");

  a_delete_clears_valid: assert property (@(posedge clk) disable iff (rst)
    del_hit |=> !slot_valid)
    else $error("delete did not clear slot");

  a_hit_not_before_home: assert property (@(posedge clk) disable iff (rst)
    (ins_hit || find_hit) |-> (tok_in.active && idx >= tok_in.home))
    else $error("slot acted outside the probe range");

endmodule

### rtl/linear_probe_hash_table.sv
// Top level of the linear probing hash table: hash stage plus a row of slot cells.
// Depends on lph_pkg, lph_hash and lph_cell.
//
// Usage:
//   Raise start with mode and key while busy is low; the request is taken at
//   that clock edge and busy rises for the whole operation. Mode insert puts
//   the key in the first empty slot at or after its home slot, lookup and
//   delete act on the first valid matching slot; probing never wraps.
//   The key is hashed into a registered probe token, which then walks the row of
//   SLOTS cells, one cell per cycle, so every request runs through the whole row
//   from acceptance to the result, whatever the outcome.
//   The result (status, found_key, slot_index) is shown for one cycle with
//   done high; busy drops at the edge that ends that cycle, so the next
//   request is taken once busy is low. The walk through the cell row sets the
//   pace: one request is in flight at a time, and a new request is taken only
//   after the previous result has been shown.
//   There is no back pressure on the result side.
//   Reset empties the table (all valid bits clear) and drops busy at once.
module linear_probe_hash_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    mode,
  input  logic [lph_pkg::KEY_BITS-1:0]  key,
  output logic                          done,
  output logic [1:0]                    status,
  output logic [lph_pkg::KEY_BITS-1:0]  found_key,
  output logic [lph_pkg::SLOT_BITS-1:0] slot_index
);

  lph_pkg::tok_t chain [lph_pkg::SLOTS+1];
  lph_pkg::tok_t last;
  logic          accept;

  assign accept = start && !busy;

  // Hash the key into a probe token
  lph_hash u_hash (
    .clk  (clk),
    .rst  (rst),
    .load (accept),
    .mode (mode),
    .key  (key),
    .tok  (chain[0])
  );

  // Row of slot cells
  for (genvar i = 0; i < lph_pkg::SLOTS; i++) begin : g_cell
    lph_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (lph_pkg::SLOT_BITS'(i)),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  assign last = chain[lph_pkg::SLOTS];

  // Hold busy from acceptance until the result cycle ends
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (last.active) begin
      busy <= 1'b0;
    end
  end

  // Build the result from the token leaving the last cell
  always_comb begin
    done       = last.active;
    status     = lph_pkg::STATUS_MISS;
    found_key  = '0;
    slot_index = '0;
    if (last.hit) begin
      status     = lph_pkg::STATUS_OK;
      slot_index = last.slot;
      if (last.mode == lph_pkg::MODE_LOOKUP) begin
        found_key = last.key;
      end
    end else if (last.mode == lph_pkg::MODE_INSERT) begin
      status = lph_pkg::STATUS_FULL;
    end
  end

  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("busy stayed high after result");

  a_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result without an open request");

  a_accept_sets_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy && !done))
    else $error("request accepted but busy not raised");

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    (chain[0].active && busy) |-> !done)
    else $error("two probe tokens in flight");

endmodule

### verif/lph_checker.sv
`timescale 1ns / 1ps
// Checker for the linear probing hash table: mirrors the slot table, predicts the
// result of each accepted request and compares it with the reported result.
// Depends on lph_pkg for widths, the hash multiplier, operation and status codes.
module lph_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic [1:0]                    mode,
  input  logic [lph_pkg::KEY_BITS-1:0]  key,
  input  logic                          done,
  input  logic [1:0]                    status,
  input  logic [lph_pkg::KEY_BITS-1:0]  found_key,
  input  logic [lph_pkg::SLOT_BITS-1:0] slot_index,
  output int                            errors,
  output int                            outstanding,
  output int                            ok_seen,
  output int                            miss_seen,
  output int                            full_seen
);

  typedef struct packed {
    logic [1:0]                    status;
    logic [lph_pkg::KEY_BITS-1:0]  found_key;
    logic [lph_pkg::SLOT_BITS-1:0] slot;
  } reply_t;

  // Shadow copy of the slot table
  logic [lph_pkg::KEY_BITS-1:0] shadow_key [lph_pkg::SLOTS];
  logic [lph_pkg::SLOTS-1:0]    shadow_used;
  reply_t                       replies_due [$];
  int                           n_err = 0;
  int                           n_ok = 0;
  int                           n_miss = 0;
  int                           n_full = 0;

  // Home slot: top bits of the low word of key times the golden-ratio fraction
  function automatic logic [lph_pkg::SLOT_BITS-1:0] home_of(
      input logic [lph_pkg::KEY_BITS-1:0] k);
    logic [63:0] prod;
    prod = 64'(k) * 64'(lph_pkg::HOME_MULT);
    return prod[31:32-lph_pkg::SLOT_BITS];
  endfunction

  // Apply one request to the shadow table and work out its reply
  task automatic apply_request(input logic [1:0] op,
                               input logic [lph_pkg::KEY_BITS-1:0] k,
                               output reply_t r);
    int s;
    r.status    = lph_pkg::STATUS_MISS;
    r.found_key = '0;
    r.slot      = '0;
    case (op)
      lph_pkg::MODE_INSERT: begin
        r.status = lph_pkg::STATUS_FULL;
        for (s = int'(home_of(k)); s < lph_pkg::SLOTS; s++) begin
          if (!shadow_used[s]) begin
            shadow_used[s] = 1'b1;
            shadow_key[s]  = k;
            r.status       = lph_pkg::STATUS_OK;
            r.slot         = lph_pkg::SLOT_BITS'(s);
            break;
          end
        end
      end
      lph_pkg::MODE_LOOKUP, lph_pkg::MODE_DELETE: begin
        for (s = int'(home_of(k)); s < lph_pkg::SLOTS; s++) begin
          if (shadow_used[s] && shadow_key[s] == k) begin
            r.status = lph_pkg::STATUS_OK;
            r.slot   = lph_pkg::SLOT_BITS'(s);
            if (op == lph_pkg::MODE_LOOKUP) r.found_key = k;
            else shadow_used[s] = 1'b0;
            break;
          end
        end
      end
      default: begin
        // unused mode: table untouched, reported as a miss
      end
    endcase
  endtask

  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (rst) begin
      shadow_used = '0;
      replies_due.delete();
    end else begin
      // Compare a reported result with the oldest pending reply
      if (done) begin
        got.status    = status;
        got.found_key = found_key;
        got.slot      = slot_index;
        case (status)
          lph_pkg::STATUS_OK:   n_ok++;
          lph_pkg::STATUS_FULL: n_full++;
          default:              n_miss++;
        endcase
        if (replies_due.size() == 0) begin
          n_err++;
          if (n_err <= 10)
            $display("%0t: result with no request pending: %s %0d key %h slot %0d",
                     $realtime, "status", got.status, got.found_key, got.slot);
        end else begin
          want = replies_due.pop_front();
          if (got.status !== want.status || got.found_key !== want.found_key ||
              got.slot !== want.slot) begin
            n_err++;
            if (n_err <= 10)
              $display("%0t: mismatch: expected status %0d key %h slot %0d, %s",
                       $realtime, want.status, want.found_key, want.slot,
                       $sformatf("got status %0d key %h slot %0d",
                                 got.status, got.found_key, got.slot));
          end
        end
      end
      // Predict the reply of a newly accepted request
      if (start && !busy) begin
        apply_request(mode, key, want);
        replies_due.push_back(want);
      end
    end
    errors      <= n_err;
    outstanding <= replies_due.size();
    ok_seen     <= n_ok;
    miss_seen   <= n_miss;
    full_seen   <= n_full;
  end

endmodule

### verif/linear_probe_hash_table_tb.sv
`timescale 1ns / 1ps
// Testbench top for the linear probing hash table: clock, reset, request stimulus, verdict.
// Depends on lph_pkg, the RTL top linear_probe_hash_table and lph_checker.
module linear_probe_hash_table_tb;

  localparam logic [1:0]                   MODE_UNUSED   = 2'd3;
  localparam logic [lph_pkg::KEY_BITS-1:0] KEY_MAX       = '1;
  localparam logic [lph_pkg::KEY_BITS-1:0] KEY_ODD_BITS  = 31'h2AAAAAAA;
  localparam logic [lph_pkg::KEY_BITS-1:0] KEY_EVEN_BITS = 31'h55555555;
  localparam int RANDOM_REQS   = 1280;
  localparam int CALM_TAIL     = 150;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 400000;

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic                          busy;
  logic [1:0]                    mode;
  logic [lph_pkg::KEY_BITS-1:0]  key;
  logic                          done;
  logic [1:0]                    status;
  logic [lph_pkg::KEY_BITS-1:0]  found_key;
  logic [lph_pkg::SLOT_BITS-1:0] slot_index;
  int                            errors;
  int                            outstanding;
  int                            ok_seen;
  int                            miss_seen;
  int                            full_seen;
  int                            cycles = 0;
  int                            mode_count [4];
  logic [lph_pkg::KEY_BITS-1:0]  key_pool [$];

  linear_probe_hash_table dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .mode       (mode),
    .key        (key),
    .done       (done),
    .status     (status),
    .found_key  (found_key),
    .slot_index (slot_index)
  );

  lph_checker probe_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .key         (key),
    .done        (done),
    .status      (status),
    .found_key   (found_key),
    .slot_index  (slot_index),
    .errors      (errors),
    .outstanding (outstanding),
    .ok_seen     (ok_seen),
    .miss_seen   (miss_seen),
    .full_seen   (full_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // Present one request and hold it until the block takes it
  task automatic send_request(input logic [1:0] op,
                              input logic [lph_pkg::KEY_BITS-1:0] k);
    start <= 1'b1;
    mode  <= op;
    key   <= k;
    do @(posedge clk); while (busy);
    mode_count[op]++;
    if (op == lph_pkg::MODE_INSERT) begin
      key_pool.push_back(k);
      if (key_pool.size() > 24) void'(key_pool.pop_front());
    end
  endtask

  // Drop start for a burst, either inside the operation or after busy falls
  task automatic pause_requests();
    int n;
    n = $urandom_range(12, 1);
    start <= 1'b0;
    if ($urandom_range(1, 0) == 1) begin
      do @(posedge clk); while (busy);
    end
    repeat (n) @(posedge clk);
  endtask

  // Pick a key: often one inserted earlier, sometimes an extreme or a small one
  function automatic logic [lph_pkg::KEY_BITS-1:0] pick_key(input int known_pct);
    int r;
    r = $urandom_range(99, 0);
    if (key_pool.size() > 0 && r < known_pct)
      return key_pool[$urandom_range(key_pool.size() - 1, 0)];
    if (r >= 97) return ($urandom_range(1, 0) == 1) ? KEY_MAX : '0;
    if (r >= 92) return lph_pkg::KEY_BITS'($urandom_range(15, 0));
    return lph_pkg::KEY_BITS'($urandom);
  endfunction

  initial begin
    int i;
    int roll;
    int mix;
    int idle_pct;
    logic [1:0] op;
    foreach (mode_count[m]) mode_count[m] = 0;
    rst   <= 1'b1;
    start <= 1'b0;
    mode  <= lph_pkg::MODE_INSERT;
    key   <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, duplicates, full run to the end, misses, unused mode
    send_request(lph_pkg::MODE_INSERT, '0);
    send_request(lph_pkg::MODE_INSERT, KEY_MAX);        // home is slot 14
    send_request(lph_pkg::MODE_INSERT, KEY_MAX);        // duplicate lands in slot 15
    send_request(lph_pkg::MODE_INSERT, KEY_MAX);        // no empty slot up to the end
    send_request(lph_pkg::MODE_LOOKUP, KEY_MAX);
    send_request(lph_pkg::MODE_DELETE, KEY_MAX);
    send_request(lph_pkg::MODE_LOOKUP, KEY_MAX);        // second copy now visible
    send_request(lph_pkg::MODE_LOOKUP, '0);
    send_request(lph_pkg::MODE_LOOKUP, KEY_EVEN_BITS);
    send_request(lph_pkg::MODE_DELETE, KEY_ODD_BITS);
    send_request(MODE_UNUSED, KEY_MAX);
    send_request(MODE_UNUSED, '0);
    send_request(lph_pkg::MODE_DELETE, '0);
    send_request(lph_pkg::MODE_LOOKUP, '0);
    send_request(lph_pkg::MODE_DELETE, '0);
    send_request(lph_pkg::MODE_INSERT, KEY_MAX);        // reuses the freed slot
    send_request(lph_pkg::MODE_INSERT, KEY_ODD_BITS);
    send_request(lph_pkg::MODE_INSERT, KEY_EVEN_BITS);
    send_request(lph_pkg::MODE_LOOKUP, KEY_ODD_BITS);
    send_request(lph_pkg::MODE_LOOKUP, KEY_EVEN_BITS);
    send_request(lph_pkg::MODE_DELETE, KEY_MAX);
    send_request(lph_pkg::MODE_DELETE, KEY_MAX);

    // Random: alternate fill, balanced and drain phases
    for (i = 0; i < RANDOM_REQS; i++) begin
      mix      = (i / 150) % 3;
      idle_pct = (i >= RANDOM_REQS - CALM_TAIL) ? 0 : ((i / 64) % 3) * 30;
      if ($urandom_range(99, 0) < idle_pct) pause_requests();
      roll = $urandom_range(99, 0);
      if (roll >= 95) op = MODE_UNUSED;
      else if (mix == 0)
        op = (roll < 60) ? lph_pkg::MODE_INSERT :
             (roll < 80) ? lph_pkg::MODE_LOOKUP : lph_pkg::MODE_DELETE;
      else if (mix == 1)
        op = (roll < 35) ? lph_pkg::MODE_INSERT :
             (roll < 70) ? lph_pkg::MODE_LOOKUP : lph_pkg::MODE_DELETE;
      else
        op = (roll < 15) ? lph_pkg::MODE_INSERT :
             (roll < 50) ? lph_pkg::MODE_LOOKUP : lph_pkg::MODE_DELETE;
      send_request(op, pick_key((op == lph_pkg::MODE_INSERT) ? 15 : 75));
    end
    start <= 1'b0;

    // Drain the last result, then let the block settle
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d requests: %0d inserts, %0d lookups, %0d deletes, %0d unused mode",
             mode_count[0] + mode_count[1] + mode_count[2] + mode_count[3],
             mode_count[lph_pkg::MODE_INSERT], mode_count[lph_pkg::MODE_LOOKUP],
             mode_count[lph_pkg::MODE_DELETE], mode_count[MODE_UNUSED]);
    $display("results: %0d done or found, %0d not found, %0d table full, %0d mismatches",
             ok_seen, miss_seen, full_seen, errors);
    if (errors == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/lph_pkg.sv
rtl/lph_hash.sv
rtl/lph_cell.sv
rtl/linear_probe_hash_table.sv
verif/lph_checker.sv
verif/linear_probe_hash_table_tb.sv
